### rtl/core/nphs_pkg.sv
// Shared constants and helpers for the nearest point haversine search core.
package nphs_pkg;

    localparam int unsigned IN_BYTES  = 10;
    localparam int unsigned OUT_BYTES = 6;

    localparam logic [0:0] CFG_HOME_LAT = 1'b0;
    localparam logic [0:0] CFG_HOME_LON = 1'b1;

    localparam logic [25:0] DIST_BOUND   = 26'd40100000;
    localparam logic [23:0] TWO_RADIUS   = 24'd12742016;
    localparam logic [31:0] PI_Q30       = 32'd3373259426;
    localparam logic [30:0] HALF_PI_Q30  = 31'd1686629713;
    localparam logic [30:0] ONE_Q30      = 31'd1073741824;
    localparam logic [29:0] TURN_H       = 30'd720000000;
    localparam logic [29:0] HALF_TURN_H  = 30'd360000000;
    localparam logic [29:0] QUARTER_H    = 30'd180000000;
    localparam logic [28:0] DIV_CONST    = 29'd360000000;
    localparam logic [31:0] DIV_RECIP    = 32'd3202559735;
    localparam logic [4:0]  BIS_STEPS    = 5'd31;
    localparam logic [2:0]  LAST_TERM    = 3'd6;

    function automatic logic [31:0] term_recip(input logic [2:0] k);
        logic [31:0] m;
        case (k)
            3'd0: m = 32'd2863311530;
            3'd1: m = 32'd858993459;
            3'd2: m = 32'd409044504;
            3'd3: m = 32'd238609294;
            3'd4: m = 32'd156180628;
            3'd5: m = 32'd110127366;
            3'd6: m = 32'd81808900;
            default: m = 32'd0;
        endcase
        return m;
    endfunction

    function automatic logic [7:0] term_den(input logic [2:0] k);
        logic [7:0] d;
        case (k)
            3'd0: d = 8'd6;
            3'd1: d = 8'd20;
            3'd2: d = 8'd42;
            3'd3: d = 8'd72;
            3'd4: d = 8'd110;
            3'd5: d = 8'd156;
            3'd6: d = 8'd210;
            default: d = 8'd1;
        endcase
        return d;
    endfunction

endpackage

### rtl/core/nearest_point_haversine_search_core.sv
// Points are worked one at a time; the shared multiplier runs the sine series
// inside the 31-step arcsine bisection, and each of four angles takes a reciprocal division.
// A new point is taken only once the last one is done and, after a point marked last,
// once its result word is loaded; s_tready is high only while no point is in work.
// A result word appears after the point marked last and waits in an output register.
// Reset (aresetn low, synchronous) clears the home point, the running minimum
// to 40100000 m, the found flag and all handshake state.
module nearest_point_haversine_search_core #(
    parameter int unsigned INDEX_BITS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // point_latitude[27:0], point_longitude[56:28], point_index[72:57]
    input  logic [nphs_pkg::IN_BYTES*8-1:0] s_tdata,
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // nearest_index[15:0], nearest_distance[41:16]
    output logic [nphs_pkg::OUT_BYTES*8-1:0] m_tdata,
    // found[0]
    output logic [0:0]                      m_tuser,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [0:0]                      cfg_index,
    input  logic [28:0]                     cfg_data
);
    import nphs_pkg::*;

    localparam logic [15:0] IDX_MASK = (INDEX_BITS >= 16) ? 16'hFFFF :
        16'((32'd1 << INDEX_BITS) - 32'd1);

    typedef enum logic [27:0] {
        S_IDLE = 28'd1 << 0,  S_RED  = 28'd1 << 1,  S_FOLD = 28'd1 << 2,
        S_XM   = 28'd1 << 3,  S_XD   = 28'd1 << 4,  S_XW   = 28'd1 << 5,
        S_SIN0 = 28'd1 << 6,  S_SIN1 = 28'd1 << 7,  S_TM   = 28'd1 << 8,
        S_TN   = 28'd1 << 9,  S_TQ   = 28'd1 << 10, S_TC   = 28'd1 << 11,
        S_SCL  = 28'd1 << 12, S_ANG  = 28'd1 << 13, S_A1   = 28'd1 << 14,
        S_A2   = 28'd1 << 15, S_A3   = 28'd1 << 16, S_A4   = 28'd1 << 17,
        S_A5   = 28'd1 << 18, S_BINIT = 28'd1 << 19, S_BTOP = 28'd1 << 20,
        S_BSQ  = 28'd1 << 21, S_BCMP = 28'd1 << 22, S_DM   = 28'd1 << 23,
        S_DW   = 28'd1 << 24, S_EMIT = 28'd1 << 25, S_XR   = 28'd1 << 26,
        S_XQ   = 28'd1 << 27
    } state_t;

    state_t state_reg, state_next;

    logic signed [27:0] home_lat_reg;
    logic signed [28:0] home_lon_reg;
    logic signed [27:0] lat_reg;
    logic signed [28:0] lon_reg;
    logic [15:0]        idx_reg;
    logic               last_reg;

    logic [1:0]  ang_reg;
    logic [29:0] r_reg;
    logic        neg_reg;
    logic [59:0] num_reg;
    logic [30:0] x_reg;
    logic [31:0] x2_reg;
    logic [31:0] term_reg;
    logic [31:0] n_reg;
    logic [29:0] q_reg;
    logic [2:0]  k_reg;
    logic signed [33:0] sum_reg;
    logic [30:0] sin_reg;
    logic        bis_reg;
    logic [30:0] mag_reg [4];
    logic        sgn_reg [4];
    logic [31:0] s1sq_reg;
    logic [31:0] cp_reg;
    logic [30:0] a_reg;
    logic [30:0] lo_reg;
    logic [30:0] hi_reg;
    logic [4:0]  it_reg;

    logic [25:0] best_dist_reg;
    logic [15:0] best_idx_reg;
    logic        have_best_reg;

    logic        m_valid_reg;
    logic [15:0] out_idx_reg;
    logic [25:0] out_dist_reg;
    logic        out_found_reg;

    logic [31:0] mul_a, mul_b;
    logic [63:0] prod_reg;
    logic [30:0] div_quot;

    logic signed [30:0] h_sel;
    logic signed [30:0] h_wrap;
    logic [29:0] r_half;
    logic [29:0] r_fold;
    logic        fold_neg;
    logic [31:0] rem_c;
    logic [29:0] q_fix;
    logic signed [33:0] a_sum;
    logic [31:0] mid_sum;
    logic [55:0] dist_sum;
    logic [25:0] dist_m;

    nphs_mul u_mul (
        .aclk     (aclk),
        .op_a     (mul_a),
        .op_b     (mul_b),
        .prod_reg (prod_reg)
    );

    nphs_div u_div (
        .num    (num_reg),
        .q_est  (x_reg),
        .q_prod (prod_reg[59:0]),
        .quot   (div_quot)
    );

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {6'd0, out_dist_reg, out_idx_reg};
    assign m_tuser   = out_found_reg;

    always_comb begin
        case (ang_reg)
            2'd0: h_sel = 31'(home_lat_reg) - 31'(lat_reg);
            2'd1: h_sel = 31'(home_lon_reg) - 31'(lon_reg);
            2'd2: h_sel = (31'(home_lat_reg) <<< 1) + 31'sd180000000;
            default: h_sel = (31'(lat_reg) <<< 1) + 31'sd180000000;
        endcase
        h_wrap = (h_sel < 0) ? h_sel + 31'sd720000000 : h_sel;
        fold_neg = (r_reg >= HALF_TURN_H);
        r_half = fold_neg ? r_reg - HALF_TURN_H : r_reg;
        r_fold = (r_half > QUARTER_H) ? HALF_TURN_H - r_half : r_half;
        rem_c = n_reg - prod_reg[31:0];
        q_fix = (rem_c >= 32'(term_den(k_reg))) ? q_reg + 30'd1 : q_reg;
        a_sum = sgn_reg[2] ^ sgn_reg[3] ?
            34'(s1sq_reg) - 34'(prod_reg[61:30]) :
            34'(s1sq_reg) + 34'(prod_reg[61:30]);
        mid_sum  = 32'(lo_reg) + 32'(hi_reg) + 32'd1;
        dist_sum = prod_reg[55:0] + 56'(32'd1 << 29);
        dist_m   = dist_sum[55:30];
    end

    always_comb begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        case (state_reg)
            S_XM: begin
                mul_a = 32'(r_reg);
                mul_b = PI_Q30;
            end
            S_XR: begin
                mul_a = num_reg[59:28];
                mul_b = DIV_RECIP;
            end
            S_XQ: begin
                mul_a = 32'(prod_reg[62:32]);
                mul_b = 32'(DIV_CONST);
            end
            S_SIN0: begin
                mul_a = 32'(x_reg);
                mul_b = 32'(x_reg);
            end
            S_TM: begin
                mul_a = term_reg;
                mul_b = x2_reg;
            end
            S_TN: begin
                mul_a = prod_reg[61:30];
                mul_b = term_recip(k_reg);
            end
            S_TQ: begin
                mul_a = 32'(prod_reg[63:34]);
                mul_b = 32'(term_den(k_reg));
            end
            S_A1: begin
                mul_a = 32'(mag_reg[0]);
                mul_b = 32'(mag_reg[0]);
            end
            S_A2: begin
                mul_a = 32'(mag_reg[2]);
                mul_b = 32'(mag_reg[3]);
            end
            S_A3: begin
                mul_a = 32'(mag_reg[1]);
                mul_b = 32'(mag_reg[1]);
            end
            S_A4: begin
                mul_a = cp_reg;
                mul_b = prod_reg[61:30];
            end
            S_BSQ: begin
                mul_a = 32'(sin_reg);
                mul_b = 32'(sin_reg);
            end
            S_DM: begin
                mul_a = 32'(lo_reg);
                mul_b = 32'(TWO_RADIUS);
            end
            default: begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (s_tvalid) state_next = S_RED;
            S_RED:   state_next = S_FOLD;
            S_FOLD:  state_next = S_XM;
            S_XM:    state_next = S_XD;
            S_XD:    state_next = S_XR;
            S_XR:    state_next = S_XQ;
            S_XQ:    state_next = S_XW;
            S_XW:    state_next = S_SIN0;
            S_SIN0:  state_next = S_SIN1;
            S_SIN1:  state_next = S_TM;
            S_TM:    state_next = S_TN;
            S_TN:    state_next = S_TQ;
            S_TQ:    state_next = S_TC;
            S_TC:    state_next = (k_reg == LAST_TERM) ? S_SCL : S_TM;
            S_SCL:   state_next = bis_reg ? S_BSQ : S_ANG;
            S_ANG:   state_next = (ang_reg == 2'd3) ? S_A1 : S_RED;
            S_A1:    state_next = S_A2;
            S_A2:    state_next = S_A3;
            S_A3:    state_next = S_A4;
            S_A4:    state_next = S_A5;
            S_A5:    state_next = S_BINIT;
            S_BINIT: state_next = S_BTOP;
            S_BTOP:  state_next = (it_reg == BIS_STEPS || lo_reg >= hi_reg) ? S_DM : S_SIN0;
            S_BSQ:   state_next = S_BCMP;
            S_BCMP:  state_next = S_BTOP;
            S_DM:    state_next = S_DW;
            S_DW:    state_next = last_reg ? S_EMIT : S_IDLE;
            S_EMIT:  if (!m_valid_reg || m_tready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            home_lat_reg  <= '0;
            home_lon_reg  <= '0;
            best_dist_reg <= DIST_BOUND;
            best_idx_reg  <= 16'd0;
            have_best_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            ang_reg       <= 2'd0;
            bis_reg       <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_HOME_LAT) begin
                    home_lat_reg <= cfg_data[27:0];
                end else begin
                    home_lon_reg <= cfg_data;
                end
            end
            if (state_reg == S_EMIT && (!m_valid_reg || m_tready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    ang_reg <= 2'd0;
                    bis_reg <= 1'b0;
                end
                S_ANG: ang_reg <= ang_reg + 2'd1;
                S_BINIT: bis_reg <= 1'b1;
                S_DW: begin
                    if (dist_m < best_dist_reg) begin
                        best_dist_reg <= dist_m;
                        best_idx_reg  <= idx_reg;
                        have_best_reg <= 1'b1;
                    end
                end
                S_EMIT: begin
                    if (!m_valid_reg || m_tready) begin
                        best_dist_reg <= DIST_BOUND;
                        best_idx_reg  <= 16'd0;
                        have_best_reg <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                lat_reg  <= s_tdata[27:0];
                lon_reg  <= s_tdata[56:28];
                idx_reg  <= s_tdata[72:57] & IDX_MASK;
                last_reg <= s_tlast;
            end
            S_RED: r_reg <= h_wrap[29:0];
            S_FOLD: begin
                r_reg   <= r_fold;
                neg_reg <= fold_neg;
            end
            S_XD: num_reg <= prod_reg[59:0] + 60'(QUARTER_H);
            S_XQ: x_reg <= prod_reg[62:32];
            S_XW: x_reg <= div_quot;
            S_SIN1: begin
                x2_reg   <= prod_reg[61:30];
                term_reg <= 32'(x_reg);
                sum_reg  <= 34'(x_reg);
                k_reg    <= 3'd0;
            end
            S_TN: n_reg <= prod_reg[61:30];
            S_TQ: q_reg <= prod_reg[63:34];
            S_TC: begin
                term_reg <= 32'(q_fix);
                sum_reg  <= k_reg[0] ? sum_reg + 34'(q_fix) : sum_reg - 34'(q_fix);
                k_reg    <= k_reg + 3'd1;
            end
            S_SCL: begin
                if (sum_reg < 0) begin
                    sin_reg <= 31'd0;
                end else if (sum_reg > 34'(ONE_Q30)) begin
                    sin_reg <= ONE_Q30;
                end else begin
                    sin_reg <= sum_reg[30:0];
                end
            end
            S_ANG: begin
                mag_reg[ang_reg] <= sin_reg;
                sgn_reg[ang_reg] <= neg_reg;
            end
            S_A2: s1sq_reg <= prod_reg[61:30];
            S_A3: cp_reg <= prod_reg[61:30];
            S_A5: begin
                if (a_sum < 0) begin
                    a_reg <= 31'd0;
                end else if (a_sum > 34'(ONE_Q30)) begin
                    a_reg <= ONE_Q30;
                end else begin
                    a_reg <= a_sum[30:0];
                end
            end
            S_BINIT: begin
                lo_reg <= 31'd0;
                hi_reg <= HALF_PI_Q30;
                it_reg <= 5'd0;
            end
            S_BTOP: x_reg <= mid_sum[31:1];
            S_BCMP: begin
                if (prod_reg[61:30] <= 32'(a_reg)) begin
                    lo_reg <= x_reg;
                end else begin
                    hi_reg <= x_reg - 31'd1;
                end
                it_reg <= it_reg + 5'd1;
            end
            S_EMIT: begin
                if (!m_valid_reg || m_tready) begin
                    out_idx_reg   <= best_idx_reg;
                    out_dist_reg  <= best_dist_reg;
                    out_found_reg <= have_best_reg;
                end
            end
            default: begin
            end
        endcase
    end

    a_found_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        have_best_reg |-> best_dist_reg < DIST_BOUND)
        else $error("kept distance not below bound");

    a_not_found: assert property (@(posedge aclk) disable iff (!aresetn)
        !have_best_reg |-> best_dist_reg == DIST_BOUND && best_idx_reg == 16'd0)
        else $error("empty search holds a stale minimum");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_tready |=> m_valid_reg)
        else $error("result word dropped before acceptance");

    a_bis_order: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_BCMP |=> lo_reg <= hi_reg)
        else $error("bisection bounds crossed");

    a_emit_load: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_EMIT && (!m_valid_reg || m_tready) |=> m_valid_reg && !have_best_reg)
        else $error("result not loaded or minimum not cleared");

endmodule

### rtl/core/nphs_mul.sv
// Shared registered 32 by 32 unsigned multiplier.
module nphs_mul (
    input  logic        aclk,
    input  logic [31:0] op_a,
    input  logic [31:0] op_b,
    output logic [63:0] prod_reg
);
    always_ff @(posedge aclk) begin
        prod_reg <= 64'(op_a) * 64'(op_b);
    end
endmodule

### rtl/core/nphs_div.sv
// Quotient fixup for the reciprocal division by the angle scale constant.
module nphs_div (
    input  logic [59:0] num,
    input  logic [30:0] q_est,
    input  logic [59:0] q_prod,
    output logic [30:0] quot
);
    import nphs_pkg::*;

    logic [59:0] rem;

    always_comb begin
        rem = num - q_prod;
        if (rem >= (60'(DIV_CONST) << 1)) begin
            quot = q_est + 31'd2;
        end else if (rem >= 60'(DIV_CONST)) begin
            quot = q_est + 31'd1;
        end else begin
            quot = q_est;
        end
    end
endmodule

### dv/tb.sv
// Self-checking testbench for the nearest point haversine search core.
`timescale 1ns / 1ps

module tb;
    import nphs_pkg::*;

    typedef struct {
        logic signed [27:0] lat;
        logic signed [28:0] lon;
        logic [15:0]        idx;
        logic               last;
    } point_t;

    typedef struct {
        logic [15:0] idx;
        logic [25:0] meters;
        logic        found;
    } nearest_t;

    localparam longint TURN    = 720000000;
    localparam longint HALF    = 360000000;
    localparam longint QUARTER = 180000000;
    localparam longint PIQ     = 64'd3373259426;
    localparam longint ONEQ    = 1073741824;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_BYTES*8-1:0] s_tdata = '0;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_BYTES*8-1:0] m_tdata;
    logic [0:0] m_tuser;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [0:0] cfg_index = CFG_HOME_LAT;
    logic [28:0] cfg_data = '0;

    point_t   point_q[$];
    nearest_t nearest_q[$];
    longint   home_lat, home_lon;
    logic [25:0] run_dist;
    logic [15:0] run_idx;
    logic        run_found;
    int  errors;
    int  results_seen;
    int  hold_cnt;
    bit  hold_done;
    bit  taken;
    longint cyc;

    nearest_point_haversine_search_core dut (.*);

    always #1 aclk = ~aclk;

    function automatic longint sin_q30(longint x);
        longint unsigned ux, x2, term;
        longint sum;
        ux = x;
        x2 = (ux * ux) >> 30;
        term = ux;
        sum = x;
        for (int k = 1; k <= 7; k++) begin
            term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
            if (k & 1) sum -= longint'(term);
            else sum += longint'(term);
        end
        if (sum < 0) sum = 0;
        if (sum > ONEQ) sum = ONEQ;
        return sum;
    endfunction

    function automatic longint sin_half_deg(longint h);
        longint r, x;
        bit neg;
        r = h % TURN;
        neg = 0;
        if (r < 0) r += TURN;
        if (r >= HALF) begin
            neg = 1;
            r -= HALF;
        end
        if (r > QUARTER) r = HALF - r;
        x = sin_q30((r * PIQ + QUARTER) / HALF);
        return neg ? -x : x;
    endfunction

    function automatic logic [25:0] great_circle_m(longint lat, longint lon);
        longint s1, s2, c1, c2, a, lo, hi, mid, s;
        longint unsigned d;
        s1 = sin_half_deg(home_lat - lat);
        s2 = sin_half_deg(home_lon - lon);
        c1 = sin_half_deg(2 * home_lat + QUARTER);
        c2 = sin_half_deg(2 * lat + QUARTER);
        a = (s1 * s1) / ONEQ + (((c1 * c2) / ONEQ) * ((s2 * s2) / ONEQ)) / ONEQ;
        if (a < 0) a = 0;
        if (a > ONEQ) a = ONEQ;
        lo = 0;
        hi = PIQ / 2;
        for (int i = 0; i < 31; i++) begin
            if (lo < hi) begin
                mid = (lo + hi + 1) / 2;
                s = sin_q30(mid);
                if ((s * s) / ONEQ <= a) lo = mid;
                else hi = mid - 1;
            end
        end
        d = (longint'(12742016) * lo + (longint'(1) << 29)) >> 30;
        return d[25:0];
    endfunction

    task automatic track_point(point_t p);
        logic [25:0] d;
        nearest_t n;
        d = great_circle_m(longint'(p.lat), longint'(p.lon));
        if (d < run_dist) begin
            run_dist = d;
            run_idx = p.idx;
            run_found = 1'b1;
        end
        if (p.last) begin
            n.idx = run_idx;
            n.meters = run_dist;
            n.found = run_found;
            nearest_q.push_back(n);
            run_dist = DIST_BOUND;
            run_idx = '0;
            run_found = 1'b0;
        end
    endtask

    function automatic bit idle_now();
        return ($urandom_range(99) < 26) && !(cyc > 300000 && cyc < 450000);
    endfunction

    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                results_seen <= results_seen + 1;
                if (nearest_q.size() == 0) begin
                    $error("unexpected result word idx=%0d", m_tdata[15:0]);
                    errors++;
                end else begin
                    if (m_tdata[15:0] !== nearest_q[0].idx) begin
                        $error("nearest_index exp=%0d act=%0d", nearest_q[0].idx,
                               m_tdata[15:0]);
                        errors++;
                    end
                    if (m_tdata[41:16] !== nearest_q[0].meters) begin
                        $error("nearest_distance exp=%0d act=%0d", nearest_q[0].meters,
                               m_tdata[41:16]);
                        errors++;
                    end
                    if (m_tuser[0] !== nearest_q[0].found) begin
                        $error("found exp=%0d act=%0d", nearest_q[0].found, m_tuser[0]);
                        errors++;
                    end
                    void'(nearest_q.pop_front());
                end
            end
            if (s_tvalid && s_tready) begin
                track_point(point_q[0]);
                void'(point_q.pop_front());
                taken <= 1'b1;
            end
        end
    end

    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && !taken) begin
                s_tvalid <= 1'b1;
            end else if (point_q.size() > 0 && !idle_now()) begin
                s_tvalid <= 1'b1;
                s_tdata <= {7'b0, point_q[0].idx, point_q[0].lon, point_q[0].lat};
                s_tlast <= point_q[0].last;
            end else begin
                s_tvalid <= 1'b0;
            end
            taken <= 1'b0;
        end
    end

    always @(negedge aclk) begin
        if (aresetn) begin
            if (!hold_done && results_seen == 12) begin
                hold_done <= 1'b1;
                hold_cnt <= 30000;
                m_tready <= 1'b0;
            end else if (hold_cnt > 0) begin
                hold_cnt <= hold_cnt - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= !idle_now();
            end
        end
    end

    task automatic write_reg(logic [0:0] idx, longint val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[28:0];
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_HOME_LAT) home_lat = longint'(signed'(val[27:0]));
        else home_lon = longint'(signed'(val[28:0]));
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic add_point(longint lat, longint lon, int idx, bit last);
        point_t p;
        p.lat = lat[27:0];
        p.lon = lon[28:0];
        p.idx = idx[15:0];
        p.last = last;
        point_q.push_back(p);
    endtask

    task automatic drain();
        wait (point_q.size() == 0 && nearest_q.size() == 0);
        repeat (3000) @(posedge aclk);
    endtask

    task automatic random_searches(int n_items);
        int left, len, near_sel;
        longint lat, lon;
        left = n_items;
        while (left > 0) begin
            len = $urandom_range(1, 8);
            if (len > left) len = left;
            for (int i = 0; i < len; i++) begin
                near_sel = $urandom_range(9);
                if (near_sel < 5) begin
                    lat = home_lat + $signed($urandom_range(2000000)) - 1000000;
                    lon = home_lon + $signed($urandom_range(2000000)) - 1000000;
                end else if (near_sel < 9) begin
                    lat = $signed($urandom_range(180000000)) - 90000000;
                    lon = $signed($urandom_range(360000000)) - 180000000;
                end else begin
                    lat = longint'($urandom);
                    lon = longint'($urandom);
                end
                add_point(lat, lon, $urandom_range(65535), i == len - 1);
            end
            left -= len;
        end
    endtask

    initial begin
        home_lat = 0;
        home_lon = 0;
        run_dist = DIST_BOUND;
        run_idx = '0;
        run_found = 1'b0;
        errors = 0;
        results_seen = 0;
        hold_cnt = 0;
        hold_done = 0;
        taken = 0;
        cyc = 0;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        add_point(0, 0, 7, 1);
        add_point(0, 180000000, 1, 0);
        add_point(90000000, 0, 2, 0);
        add_point(-90000000, 0, 3, 0);
        add_point(1000, 1000, 65535, 0);
        add_point(1000, 1000, 9, 1);
        add_point(-134217728, -268435456, 0, 0);
        add_point(134217727, 268435455, 4, 0);
        add_point(0, -180000000, 5, 1);
        add_point(12345678, -98765432, 65535, 0);
        add_point(-45000000, 90000000, 0, 1);
        drain();

        write_reg(CFG_HOME_LAT, 90000000);
        write_reg(CFG_HOME_LON, 180000000);
        add_point(90000000, 180000000, 11, 0);
        add_point(90000000, -180000000, 12, 1);
        add_point(-90000000, 0, 13, 1);
        drain();

        write_reg(CFG_HOME_LAT, -90000000);
        write_reg(CFG_HOME_LON, -180000000);
        random_searches(120);
        drain();

        write_reg(CFG_HOME_LAT, -134217728);
        write_reg(CFG_HOME_LON, 268435455);
        random_searches(80);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            write_reg(CFG_HOME_LAT, $signed($urandom_range(180000000)) - 90000000);
            write_reg(CFG_HOME_LON, $signed($urandom_range(360000000)) - 180000000);
            random_searches(130);
            drain();
        end

        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
